>>> hdl/voxel_oriented_box_cull_test_unit_defines.svh
// assertion macros shared by the cull test rtl
`ifndef VOXEL_ORIENTED_BOX_CULL_TEST_UNIT_DEFINES_SVH
`define VOXEL_ORIENTED_BOX_CULL_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked on clk_i, switched off while rst_ni is low
`define VOBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vobc assertion failed");
// checked on clk_i, also during reset
`define VOBC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("vobc reset assertion failed");
`else
`define VOBC_ASSERT(lbl, prop)
`define VOBC_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hdl/vobc_pkg.sv
package vobc_pkg;

  // voxel key width and quaternion fraction bits
  localparam int INDEX_WIDTH = 17;
  localparam int ROT_FRAC    = 14;

  // fixed field widths
  localparam int EDGE_W  = 11;
  localparam int CEN_W   = 28;
  localparam int Q_W     = 16;
  localparam int BOUND_W = 21;
  localparam int OUT_W   = 30;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;

  // reset values of the edge and rotation registers
  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(102);
  localparam logic [CFG_W-1:0]  ROT_RESET  = 64'h4000_0000_0000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOXEL_EDGE   = 3'd0,
    REG_CENTRE_X     = 3'd1,
    REG_CENTRE_Y     = 3'd2,
    REG_CENTRE_Z     = 3'd3,
    REG_BOX_ROTATION = 3'd4,
    REG_BOX_LOWER    = 3'd5,
    REG_BOX_UPPER    = 3'd6
  } vobc_reg_e;

endpackage

>>> hdl/vobc_in_if.sv
// request channel carrying one voxel key
interface vobc_in_if import vobc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [INDEX_WIDTH-1:0] cell_x;
  logic signed [INDEX_WIDTH-1:0] cell_y;
  logic signed [INDEX_WIDTH-1:0] cell_z;

  modport source (output valid, cell_x, cell_y, cell_z, input ready);
  modport sink   (input valid, cell_x, cell_y, cell_z, output ready);
endinterface

>>> hdl/vobc_out_if.sv
// result channel carrying the local coordinates and the remove flag
interface vobc_out_if import vobc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    remove_voxel;
  logic signed [OUT_W-1:0] local_x;
  logic signed [OUT_W-1:0] local_y;
  logic signed [OUT_W-1:0] local_z;

  modport source (output valid, remove_voxel, local_x, local_y, local_z, input ready);
  modport sink   (input valid, remove_voxel, local_x, local_y, local_z, output ready);
endinterface

>>> hdl/voxel_oriented_box_cull_test_unit.sv
// Oriented box cull test: each request is a voxel key; the block returns the voxel
// centre in the box frame (2^-10 m units, saturated to 30 bits) and a flag that is set
// when the centre lies outside the local box (never set if any lower bound is not below
// its upper bound). One request is taken per clock cycle while the first stage can load.
// Each result passes through six register stages, the first loading on the edge that
// takes the request: centre offset, the first multiply bank, cross product rounding,
// the second multiply bank, the second rounding and add, and the bound compare feeding
// the output register. A stalled result holds the pipe back stage by stage, so empty
// stages still fill. The user must write registers through the write port only while no
// request is in flight (the block does not enforce it); the quaternion is used as given.
`include "voxel_oriented_box_cull_test_unit_defines.svh"

module voxel_oriented_box_cull_test_unit import vobc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  vobc_in_if.sink              in_i,
  vobc_out_if.source           out_o
);

  // datapath widths, all derived from the package field widths and fraction bits
  localparam int PK_W  = INDEX_WIDTH + EDGE_W + 2;
  localparam int D_W   = ((PK_W > CEN_W + 1) ? PK_W : CEN_W + 1) + 2;
  localparam int P1_W  = Q_W + D_W;
  localparam int S1_W  = P1_W + 2;
  localparam int T_W   = S1_W - ROT_FRAC;
  localparam int P2_W  = Q_W + T_W;
  localparam int S2_W  = P2_W + 2;
  localparam int R_W   = S2_W - ROT_FRAC;
  localparam int LR_W  = ((R_W > D_W) ? R_W : D_W) + 1;
  localparam int L_W   = (LR_W > OUT_W + 2) ? LR_W : OUT_W + 2;

  localparam logic signed [S1_W-1:0] HALF1  = S1_W'(1) <<< (ROT_FRAC - 1);
  localparam logic signed [S2_W-1:0] HALF2  = S2_W'(1) <<< (ROT_FRAC - 1);
  localparam logic signed [L_W-1:0]  SAT_HI = L_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [L_W-1:0]  SAT_LO = -SAT_HI - L_W'(1);

  // configuration registers
  logic        [EDGE_W-1:0]  edge_q;
  logic signed [CEN_W-1:0]   cen_q [3];
  logic        [CFG_W-1:0]   rot_q;
  logic        [3*BOUND_W-1:0] lo_q;
  logic        [3*BOUND_W-1:0] hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= EDGE_RESET;
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      rot_q  <= ROT_RESET;
      lo_q   <= '0;
      hi_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (vobc_reg_e'(cfg_idx_i))
        REG_VOXEL_EDGE:   edge_q   <= cfg_data_i[EDGE_W-1:0];
        REG_CENTRE_X:     cen_q[0] <= $signed(cfg_data_i[CEN_W-1:0]);
        REG_CENTRE_Y:     cen_q[1] <= $signed(cfg_data_i[CEN_W-1:0]);
        REG_CENTRE_Z:     cen_q[2] <= $signed(cfg_data_i[CEN_W-1:0]);
        REG_BOX_ROTATION: rot_q    <= cfg_data_i;
        REG_BOX_LOWER:    lo_q     <= cfg_data_i[3*BOUND_W-1:0];
        REG_BOX_UPPER:    hi_q     <= cfg_data_i[3*BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // quaternion components
  logic signed [Q_W-1:0] qx, qy, qz, qw;
  assign qx = $signed(rot_q[Q_W-1:0]);
  assign qy = $signed(rot_q[2*Q_W-1:Q_W]);
  assign qz = $signed(rot_q[3*Q_W-1:2*Q_W]);
  assign qw = $signed(rot_q[4*Q_W-1:3*Q_W]);

  // stage valid bits and per-stage load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !ov_q || out_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) ov_q <= v5_q;
    end
  end

  // stage 1: centre offset in half units, key times twice the edge, plus the edge, minus twice the centre
  logic signed [D_W-1:0] k_s [3];
  logic signed [D_W-1:0] d_d [3];
  logic signed [D_W-1:0] edge2_s, edge_s;
  logic signed [D_W-1:0] d1_q [3];

  assign k_s[0]  = D_W'(in_i.cell_x);
  assign k_s[1]  = D_W'(in_i.cell_y);
  assign k_s[2]  = D_W'(in_i.cell_z);
  assign edge_s  = $signed({{(D_W-EDGE_W){1'b0}}, edge_q});
  assign edge2_s = edge_s <<< 1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_d[a] = k_s[a] * edge2_s + edge_s - (D_W'(cen_q[a]) <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) d1_q <= d_d;
  end

  // stage 2: first multiply bank for t = v x u
  logic signed [P1_W-1:0] p1_q [6];
  logic signed [D_W-1:0]  d2_q [3];

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      p1_q[0] <= P1_W'(qz) * P1_W'(d1_q[1]);
      p1_q[1] <= P1_W'(qy) * P1_W'(d1_q[2]);
      p1_q[2] <= P1_W'(qx) * P1_W'(d1_q[2]);
      p1_q[3] <= P1_W'(qz) * P1_W'(d1_q[0]);
      p1_q[4] <= P1_W'(qy) * P1_W'(d1_q[0]);
      p1_q[5] <= P1_W'(qx) * P1_W'(d1_q[1]);
      d2_q    <= d1_q;
    end
  end

  // stage 3: doubled cross product, rounded half up to half units
  logic signed [S1_W-1:0] s1_d [3];
  logic signed [T_W-1:0]  t3_q [3];
  logic signed [D_W-1:0]  d3_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s1_d[a] = ((S1_W'(p1_q[2*a]) - S1_W'(p1_q[2*a+1])) <<< 1) + HALF1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      for (int a = 0; a < 3; a++) begin
        t3_q[a] <= T_W'(s1_d[a] >>> ROT_FRAC);
      end
      d3_q <= d2_q;
    end
  end

  // stage 4: second multiply bank for w t + t x u
  logic signed [P2_W-1:0] p2_q [9];
  logic signed [D_W-1:0]  d4_q [3];

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      p2_q[0] <= P2_W'(qw) * P2_W'(t3_q[0]);
      p2_q[1] <= P2_W'(qz) * P2_W'(t3_q[1]);
      p2_q[2] <= P2_W'(qy) * P2_W'(t3_q[2]);
      p2_q[3] <= P2_W'(qw) * P2_W'(t3_q[1]);
      p2_q[4] <= P2_W'(qx) * P2_W'(t3_q[2]);
      p2_q[5] <= P2_W'(qz) * P2_W'(t3_q[0]);
      p2_q[6] <= P2_W'(qw) * P2_W'(t3_q[2]);
      p2_q[7] <= P2_W'(qy) * P2_W'(t3_q[0]);
      p2_q[8] <= P2_W'(qx) * P2_W'(t3_q[1]);
      d4_q    <= d3_q;
    end
  end

  // stage 5: round the rotation term and add the offset back
  logic signed [S2_W-1:0] s2_d [3];
  logic signed [R_W-1:0]  r_d  [3];
  logic signed [L_W-1:0]  l5_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s2_d[a] = S2_W'(p2_q[3*a]) + S2_W'(p2_q[3*a+1]) - S2_W'(p2_q[3*a+2]) + HALF2;
      r_d[a]  = R_W'(s2_d[a] >>> ROT_FRAC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      for (int a = 0; a < 3; a++) begin
        l5_q[a] <= L_W'(d4_q[a]) + L_W'(r_d[a]);
      end
    end
  end

  // stage 6: box compare and saturated output
  logic signed [BOUND_W-1:0] lo_s [3];
  logic signed [BOUND_W-1:0] hi_s [3];
  logic signed [L_W-1:0]     h_d  [3];
  logic signed [OUT_W-1:0]   loc_d [3];
  logic                      box_ok, outside;
  logic                      rm_q;
  logic signed [OUT_W-1:0]   loc_q [3];

  always_comb begin
    box_ok  = 1'b1;
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lo_s[a] = $signed(lo_q[BOUND_W*a +: BOUND_W]);
      hi_s[a] = $signed(hi_q[BOUND_W*a +: BOUND_W]);
      if (lo_s[a] >= hi_s[a]) box_ok = 1'b0;
      if ((l5_q[a] < (L_W'(lo_s[a]) <<< 1)) || (l5_q[a] > (L_W'(hi_s[a]) <<< 1))) begin
        outside = 1'b1;
      end
      h_d[a] = (l5_q[a] + L_W'(1)) >>> 1;
      priority if (h_d[a] > SAT_HI) begin
        loc_d[a] = SAT_HI[OUT_W-1:0];
      end else if (h_d[a] < SAT_LO) begin
        loc_d[a] = SAT_LO[OUT_W-1:0];
      end else begin
        loc_d[a] = h_d[a][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      rm_q  <= box_ok && outside;
      loc_q <= loc_d;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.remove_voxel = rm_q;
  assign out_o.local_x      = loc_q[0];
  assign out_o.local_y      = loc_q[1];
  assign out_o.local_z      = loc_q[2];

  // a taken request always lands in the first stage
  `VOBC_ASSERT(a_take_lands, (in_i.valid && in_i.ready) |=> v1_q)
  // requests are refused only while the first stage holds an item
  `VOBC_ASSERT(a_refuse_full, !in_i.ready |-> v1_q)
  // a result leaves only through a completed handshake
  `VOBC_ASSERT(a_out_drop, $fell(out_o.valid) |-> $past(out_o.ready))
  // no result is shown while reset is held
  `VOBC_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_o.valid)

endmodule
